// File: sv/hsi_pixel_color_classifier_top_assert.svh
// Assertion macros for the pixel color classifier checker.
// Used by hsipcc_checker.sv; needs nothing else.
`ifndef HSI_PIXEL_COLOR_CLASSIFIER_TOP_ASSERT_SVH
`define HSI_PIXEL_COLOR_CLASSIFIER_TOP_ASSERT_SVH

// Check cons in the same cycle as ante.
`define HSIPCC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante.
`define HSIPCC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/hsipcc_pkg.sv
// Shared widths, class codes and window thresholds of the pixel color classifier.
// No dependencies; used by the top level and its checker.
package hsipcc_pkg;

   localparam int CHAN_W  = 8;   // one color channel
   localparam int CLASS_W = 3;   // color class code
   localparam int SECT_W  = 3;   // hue sector 0..5
   localparam int HPRE_W  = 11;  // sector*d + offset, at most 6*255
   localparam int HNUM_W  = 17;  // 60 * hue numerator, at most 360*255
   localparam int SAT_W   = 11;  // 5 * 255
   localparam int VAL_W   = 12;  // 10 * 255

   typedef enum logic [CLASS_W-1:0] {
      CLASS_NONE,
      CLASS_RED,
      CLASS_YELLOW,
      CLASS_BLUE,
      CLASS_GREEN
   } class_type;

   // Degrees per sector
   localparam int HUE_SCALE = 60;

   // Hue window bounds in degrees
   localparam int HUE_10  = 10;
   localparam int HUE_20  = 20;
   localparam int HUE_50  = 50;
   localparam int HUE_60  = 60;
   localparam int HUE_65  = 65;
   localparam int HUE_100 = 100;
   localparam int HUE_180 = 180;
   localparam int HUE_190 = 190;
   localparam int HUE_230 = 230;
   localparam int HUE_320 = 320;
   localparam int HUE_340 = 340;
   localparam int HUE_360 = 360;

   // Value thresholds: b*max > a*255
   localparam int FULL_SCALE = 255;

endpackage

// File: sv/hsi_pixel_color_classifier_top.sv
// Top level of the pixel color classifier: four-stage pipeline from RGB to class.
// Depends on hsipcc_pkg.
//
// Use:
//  - Input channel req_*: one RGB pixel per word (req_red, req_green, req_blue),
//    taken at a clock edge where req_valid is high and req_stall is low.
//  - Output channel rsp_*: one color class per pixel (0 none, 1 red, 2 yellow,
//    3 blue, 4 green), taken where rsp_valid is high and rsp_stall is low.
//  - csr_wr_en / csr_wr_data write light_mode (0 sign windows, 1 light
//    windows); write it only while no pixel is in flight.
// Each accepted pixel passes four register stages in order (sort channels, form
// the hue numerator, compare, pick); rsp_valid shows the word in the last one.
// Throughput is one pixel per cycle while rsp_stall is low; each stage holds
// one word and has its own valid bit, so an empty stage keeps taking words while
// the output waits. When the receiver stalls, the output word holds and the
// stages behind fill; req_stall rises only once all four stages are full.
// Synchronous reset clears all valid bits and sets light_mode to sign windows.
module hsi_pixel_color_classifier_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [hsipcc_pkg::CHAN_W-1:0]  req_red,
   input  logic [hsipcc_pkg::CHAN_W-1:0]  req_green,
   input  logic [hsipcc_pkg::CHAN_W-1:0]  req_blue,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [hsipcc_pkg::CLASS_W-1:0] rsp_color_class,
   input  logic                           csr_wr_en,
   input  logic                           csr_wr_data
);
   import hsipcc_pkg::*;

   typedef struct packed {
      logic gray;
      logic sg_red_h;
      logic sg_yel_h;
      logic sg_blu_h;
      logic sg_grn_h;
      logic lt_red_h;
      logic lt_yel_h;
      logic lt_grn_h;
      logic sat_gt_2_5;
      logic sat_gt_1_2;
      logic sat_gt_1_5;
      logic sat_lt_1_5;
      logic val_gt_1_5;
      logic val_gt_1_2;
      logic val_gt_9_10;
      logic val_gt_7_10;
   } flags_type;

   // Control registers
   logic light_mode_ff, light_mode_in;
   logic a_valid_ff, a_valid_in;
   logic b_valid_ff, b_valid_in;
   logic c_valid_ff, c_valid_in;
   logic rsp_valid_ff, rsp_valid_in;

   // Stage load enables
   logic load_a, load_b, load_c, load_rsp;

   // Stage A: sorted channels and sector
   logic [CHAN_W-1:0] mx, md, mn;
   logic [SECT_W-1:0] sector;
   logic              desc;
   logic [CHAN_W-1:0] a_max_ff, a_mid_ff, a_min_ff;
   logic [SECT_W-1:0] a_sector_ff;
   logic              a_desc_ff;

   // Stage B: hue numerator over 60
   logic [CHAN_W-1:0] d, n, part;
   logic [HPRE_W-1:0] hpre;
   logic [HPRE_W-1:0] b_hpre_ff;
   logic [CHAN_W-1:0] b_d_ff, b_max_ff;
   logic              b_gray_ff;

   // Stage C: window compares
   logic [HNUM_W-1:0] hnum, dw;
   logic [HNUM_W-1:0] t10, t20, t50, t60, t65, t100, t180, t190, t230, t320, t340, t360;
   logic [SAT_W-1:0]  d5, d2, mx2s, mx1s;
   logic [VAL_W-1:0]  mxw;
   flags_type         flags, c_flags_ff;

   // Stage D: class pick
   class_type         cls;
   class_type         rsp_class_ff;

   // Advance a stage when it is empty or its word moves on
   always_comb begin
      load_rsp  = !rsp_valid_ff || !rsp_stall;
      load_c    = !c_valid_ff || load_rsp;
      load_b    = !b_valid_ff || load_c;
      load_a    = !a_valid_ff || load_b;
      req_stall = !load_a;
   end

   // Next valid bits and mode register
   always_comb begin
      a_valid_in    = load_a   ? req_valid  : a_valid_ff;
      b_valid_in    = load_b   ? a_valid_ff : b_valid_ff;
      c_valid_in    = load_c   ? b_valid_ff : c_valid_ff;
      rsp_valid_in  = load_rsp ? c_valid_ff : rsp_valid_ff;
      light_mode_in = csr_wr_en ? csr_wr_data : light_mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff    <= 1'b0;
         b_valid_ff    <= 1'b0;
         c_valid_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         light_mode_ff <= 1'b0;
      end else begin
         a_valid_ff    <= a_valid_in;
         b_valid_ff    <= b_valid_in;
         c_valid_ff    <= c_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         light_mode_ff <= light_mode_in;
      end
   end

   // Stage A: sort channels, red wins only when strictly largest
   always_comb begin
      if (req_red > req_green && req_red > req_blue) begin
         mx = req_red;
         md = (req_green > req_blue) ? req_green : req_blue;
         mn = (req_green < req_blue) ? req_green : req_blue;
      end else if (req_green > req_blue) begin
         mx = req_green;
         md = (req_red > req_blue) ? req_red : req_blue;
         mn = (req_red < req_blue) ? req_red : req_blue;
      end else begin
         mx = req_blue;
         md = (req_red > req_green) ? req_red : req_green;
         mn = (req_red < req_green) ? req_red : req_green;
      end
      // Sector: rising edge of a sector adds n, falling edge adds d - n
      if (req_red == mx) begin
         sector = (md == req_green) ? SECT_W'(0) : SECT_W'(5);
         desc   = (md != req_green);
      end else if (req_green == mx) begin
         sector = (md == req_blue) ? SECT_W'(2) : SECT_W'(1);
         desc   = (md != req_blue);
      end else begin
         sector = (md == req_red) ? SECT_W'(4) : SECT_W'(3);
         desc   = (md != req_red);
      end
   end

   always_ff @(posedge clock) begin
      if (load_a) begin
         a_max_ff    <= mx;
         a_mid_ff    <= md;
         a_min_ff    <= mn;
         a_sector_ff <= sector;
         a_desc_ff   <= desc;
      end
   end

   // Stage B: chroma range and hue numerator divided by 60
   always_comb begin
      d    = a_max_ff - a_min_ff;
      n    = a_mid_ff - a_min_ff;
      part = a_desc_ff ? (d - n) : n;
      hpre = HPRE_W'(a_sector_ff) * HPRE_W'(d) + HPRE_W'(part);
   end

   always_ff @(posedge clock) begin
      if (load_b) begin
         b_hpre_ff <= hpre;
         b_d_ff    <= d;
         b_max_ff  <= a_max_ff;
         b_gray_ff <= (a_max_ff == a_min_ff);
      end
   end

   // Stage C: hue, saturation and value compares as cross products
   always_comb begin
      hnum = HNUM_W'(b_hpre_ff) * HNUM_W'(HUE_SCALE);
      dw   = HNUM_W'(b_d_ff);
      t10  = dw * HNUM_W'(HUE_10);
      t20  = dw * HNUM_W'(HUE_20);
      t50  = dw * HNUM_W'(HUE_50);
      t60  = dw * HNUM_W'(HUE_60);
      t65  = dw * HNUM_W'(HUE_65);
      t100 = dw * HNUM_W'(HUE_100);
      t180 = dw * HNUM_W'(HUE_180);
      t190 = dw * HNUM_W'(HUE_190);
      t230 = dw * HNUM_W'(HUE_230);
      t320 = dw * HNUM_W'(HUE_320);
      t340 = dw * HNUM_W'(HUE_340);
      t360 = dw * HNUM_W'(HUE_360);
      d5   = SAT_W'(b_d_ff) * SAT_W'(5);
      d2   = SAT_W'(b_d_ff) * SAT_W'(2);
      mx2s = SAT_W'(b_max_ff) * SAT_W'(2);
      mx1s = SAT_W'(b_max_ff);
      mxw  = VAL_W'(b_max_ff);

      flags.gray     = b_gray_ff;
      flags.sg_red_h = (hnum != '0 && hnum < t10) || (hnum > t340 && hnum < t360);
      flags.sg_yel_h = hnum > t10 && hnum < t60;
      flags.sg_blu_h = hnum > t190 && hnum < t230;
      flags.sg_grn_h = hnum > t65 && hnum < t100;
      flags.lt_red_h = (hnum != '0 && hnum < t10) || (hnum > t320 && hnum < t360);
      flags.lt_yel_h = hnum > t20 && hnum < t50;
      flags.lt_grn_h = hnum > t100 && hnum < t180;

      flags.sat_gt_2_5 = d5 > mx2s;
      flags.sat_gt_1_2 = d2 > mx1s;
      flags.sat_gt_1_5 = d5 > mx1s;
      flags.sat_lt_1_5 = d5 < mx1s;

      flags.val_gt_1_5  = mxw * VAL_W'(5)  > VAL_W'(FULL_SCALE);
      flags.val_gt_1_2  = mxw * VAL_W'(2)  > VAL_W'(FULL_SCALE);
      flags.val_gt_9_10 = mxw * VAL_W'(10) > VAL_W'(9 * FULL_SCALE);
      flags.val_gt_7_10 = mxw * VAL_W'(10) > VAL_W'(7 * FULL_SCALE);
   end

   always_ff @(posedge clock) begin
      if (load_c) begin
         c_flags_ff <= flags;
      end
   end

   // Stage D: first matching window wins, gray matches nothing
   always_comb begin
      cls = CLASS_NONE;
      if (c_flags_ff.gray) begin
         cls = CLASS_NONE;
      end else if (!light_mode_ff) begin
         if (c_flags_ff.sg_red_h && c_flags_ff.sat_gt_2_5 && c_flags_ff.val_gt_1_5) begin
            cls = CLASS_RED;
         end else if (c_flags_ff.sg_yel_h && c_flags_ff.sat_gt_2_5 &&
                      c_flags_ff.val_gt_1_2) begin
            cls = CLASS_YELLOW;
         end else if (c_flags_ff.sg_blu_h && c_flags_ff.sat_gt_1_2 &&
                      c_flags_ff.val_gt_1_2) begin
            cls = CLASS_BLUE;
         end else if (c_flags_ff.sg_grn_h && c_flags_ff.sat_gt_1_5 &&
                      c_flags_ff.val_gt_1_2) begin
            cls = CLASS_GREEN;
         end
      end else begin
         if (c_flags_ff.lt_red_h && c_flags_ff.sat_lt_1_5 && c_flags_ff.val_gt_9_10) begin
            cls = CLASS_RED;
         end else if (c_flags_ff.lt_yel_h && c_flags_ff.sat_gt_2_5 &&
                      c_flags_ff.val_gt_7_10) begin
            cls = CLASS_YELLOW;
         end else if (c_flags_ff.lt_grn_h && c_flags_ff.sat_lt_1_5 &&
                      c_flags_ff.val_gt_9_10) begin
            cls = CLASS_GREEN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_class_ff <= cls;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_color_class = rsp_class_ff;

endmodule

// File: sv/hsipcc_checker.sv
// Port-level checker for the pixel color classifier, bound to the top level.
// Depends on hsipcc_pkg and hsi_pixel_color_classifier_top_assert.svh.
`include "hsi_pixel_color_classifier_top_assert.svh"

module hsipcc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic [hsipcc_pkg::CHAN_W-1:0]  req_red,
   input logic [hsipcc_pkg::CHAN_W-1:0]  req_green,
   input logic [hsipcc_pkg::CHAN_W-1:0]  req_blue,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [hsipcc_pkg::CLASS_W-1:0] rsp_color_class,
   input logic                           csr_wr_en,
   input logic                           csr_wr_data
);
   import hsipcc_pkg::*;

   logic mode_ff, mode_in;
   logic in_word;

   // Track the mode register as written on the port
   assign mode_in = csr_wr_en ? csr_wr_data : mode_ff;
   assign in_word = req_valid && !req_stall && (req_red == req_red) &&
                    (req_green == req_green) && (req_blue == req_blue);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   `HSIPCC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "output valid after reset")
   `HSIPCC_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_color_class), "stalled result changed")
   `HSIPCC_ASSERT_SAME(a_class_range, clock, reset, rsp_valid || in_word, !rsp_valid || rsp_color_class <= CLASS_GREEN, "class code out of range")
   `HSIPCC_ASSERT_SAME(a_light_no_blue, clock, reset, rsp_valid && mode_ff, rsp_color_class != CLASS_BLUE, "blue class in light mode")
   `HSIPCC_ASSERT_SAME(a_empty_no_stall, clock, reset, !rsp_valid, !req_stall, "input stalled with empty output")

endmodule

bind hsi_pixel_color_classifier_top hsipcc_checker u_hsipcc_checker (.*);
